[hw/rtl/mdli_pkg.sv]
// Shared types, constants and helpers for the modulated delay line core.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none

package mdli_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int DEPTH_DEF   = 2048;
  localparam int QUEUE_DEPTH = 2;

  localparam int KNOB_W = 16;
  localparam int RATE_W = 18;
  localparam int FRAC_W = 16;
  localparam int DLY_W  = 27;
  localparam int DINT_W = DLY_W - FRAC_W;

  // Offset that turns the signed modulation into 49152 + modulation.
  localparam logic [16:0] MOD_OFS = 17'd49152;

  // Reciprocal of 125 scaled by 2**41; exact floor for dividends below 2**34.
  localparam logic [34:0] RECIP125 = 35'd17592186045;
  localparam logic [17:0] RECIP125_LO = RECIP125[17:0];
  localparam logic [16:0] RECIP125_HI = RECIP125[34:18];

  // Reciprocal of 5 scaled by 2**24; exact floor for dividends below 2**21.
  localparam logic [21:0] RECIP5 = 22'd3355444;

  localparam int SUM_W = SAMPLE_W + 4;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [1:0] {
    CFG_TIME_KNOB   = 2'd0,
    CFG_FEEDBACK    = 2'd1,
    CFG_WET_MIX     = 2'd2,
    CFG_SAMPLE_RATE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [KNOB_W-1:0] time_knob;
    logic [KNOB_W-1:0] feedback_amount;
    logic [KNOB_W-1:0] wet_mix;
    logic [RATE_W-1:0] sample_rate;
  } mdli_cfg_t;

  localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic [SAMPLE_W-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mdli_queue.sv]
// Small register queue that decouples the delay front end from the back end.
// Depends on mdli_pkg for its default depth.
`default_nettype none

module mdli_queue #(
  parameter int WIDTH  = mdli_pkg::SAMPLE_W,
  parameter int QDEPTH = mdli_pkg::QUEUE_DEPTH,
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1,
  localparam int CW = $clog2(QDEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);
  import mdli_pkg::*;

  logic [WIDTH-1:0] q_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CW'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mdli_front.sv]
// Front end: five-stage pipeline that turns each item into a fractional delay,
// then into two read addresses, a weight and written-flags. Depends on mdli_pkg.
`default_nettype none

module mdli_front #(
  parameter int DEPTH = mdli_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int ENTRY_W = mdli_pkg::SAMPLE_W + 3 * AW + mdli_pkg::FRAC_W + 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mdli_pkg::mdli_cfg_t         cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mdli_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [mdli_pkg::SAMPLE_W-1:0] in_mod,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [ENTRY_W-1:0]               push_data
);
  import mdli_pkg::*;

  localparam int IW = AW + 2;
  localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  logic [SAMPLE_W-1:0] x1_r, x2_r, x3_r, x4_r, x5_r;
  logic [33:0]         ts1_r;
  logic [16:0]         b1_r;
  logic [33:0]         q2_r, q3_r;
  logic [51:0]         lo3_r;
  logic [DLY_W-1:0]    dly4_r;
  logic [AW-1:0]       wp5_r, i0_5_r, i1_5_r;
  logic [FRAC_W-1:0]   f5_r;
  logic                w0_5_r, w1_5_r;

  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrap_r, wrap_nxt;

  logic [33:0]       ts_prod;
  logic [16:0]       mod_ofs;
  logic [50:0]       p_full;
  logic [51:0]       lo_prod;
  logic [50:0]       hi_prod;
  logic [68:0]       dsum;
  logic [DINT_W-1:0] dint;
  logic [FRAC_W-1:0] dfrac;
  logic [IW-1:0]     d0, dm, dt, s, i0w;
  logic [AW-1:0]     i0, i1;
  logic              w0, w1;

  assign en5 = !v5_r || push_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready   = en1;
  assign push_valid = v5_r;
  assign push_data  = {x5_r, wp5_r, i0_5_r, i1_5_r, f5_r, w0_5_r, w1_5_r};

  assign ts_prod = 34'(cfg.time_knob) * 34'(cfg.sample_rate);
  assign mod_ofs = {in_mod[SAMPLE_W-1], in_mod} + MOD_OFS;
  assign p_full  = 51'(ts1_r) * 51'(b1_r);
  assign lo_prod = 52'(q2_r) * 52'(RECIP125_LO);
  assign hi_prod = 51'(q3_r) * 51'(RECIP125_HI);
  assign dsum    = {hi_prod, 18'd0} + 69'(lo3_r);

  // The read point sits the integer delay plus one behind the write point when
  // the delay has a fraction, and the weight of the later word is 1 - fraction.
  assign dint  = dly4_r[DLY_W-1:FRAC_W];
  assign dfrac = dly4_r[FRAC_W-1:0];
  assign d0    = IW'(dint);
  assign dm    = (d0 >= DEPTH_I) ? d0 - DEPTH_I : d0;
  assign dt    = dm + IW'(dfrac != '0);
  assign s     = IW'(wp_r) + DEPTH_I - dt;
  assign i0w   = (s >= DEPTH_I) ? s - DEPTH_I : s;
  assign i0    = i0w[AW-1:0];
  assign i1    = (i0 == AW'(DEPTH - 1)) ? '0 : i0 + AW'(1);
  assign w0    = wrap_r || (i0 < wp_r);
  assign w1    = wrap_r || (i1 < wp_r);

  assign wp_nxt   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign wrap_nxt = wrap_r || (wp_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      wp_r   <= '0;
      wrap_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en5 && v4_r) begin
        wp_r   <= wp_nxt;
        wrap_r <= wrap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r  <= in_sample;
      ts1_r <= ts_prod;
      b1_r  <= mod_ofs;
    end
    if (en2) begin
      x2_r <= x1_r;
      q2_r <= p_full[50:17];
    end
    if (en3) begin
      x3_r  <= x2_r;
      q3_r  <= q2_r;
      lo3_r <= lo_prod;
    end
    if (en4) begin
      x4_r   <= x3_r;
      dly4_r <= dsum[67:41];
    end
    if (en5) begin
      x5_r   <= x4_r;
      wp5_r  <= wp_r;
      i0_5_r <= i0;
      i1_5_r <= i1;
      f5_r   <= FRAC_W'(0) - dfrac;
      w0_5_r <= w0;
      w1_5_r <= w1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mdli_back.sv]
// Back end: reads the delay memory, interpolates, writes the feedback word and
// mixes the output through a five-step sequencer. Depends on mdli_pkg.
`default_nettype none

module mdli_back #(
  parameter int DEPTH = mdli_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int ENTRY_W = mdli_pkg::SAMPLE_W + 3 * AW + mdli_pkg::FRAC_W + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mdli_pkg::mdli_cfg_t           cfg,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire logic [ENTRY_W-1:0]            pop_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mdli_pkg::SAMPLE_W-1:0]      out_sample
);
  import mdli_pkg::*;

  typedef enum logic [4:0] {
    S_READ   = 5'b00001,
    S_INTERP = 5'b00010,
    S_FB     = 5'b00100,
    S_WRITE  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] j_x;
  logic [AW-1:0]       j_wp, j_i0, j_i1;
  logic [FRAC_W-1:0]   j_f;
  logic                j_w0, j_w1;
  logic                take;
  logic                out_load;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [SAMPLE_W-1:0]        x_r, y0_r, y1_r, y0h_r, delayed_r;
  logic [AW-1:0]              wp_r;
  logic [FRAC_W-1:0]          f_r;
  logic                       w0_r, w1_r;
  logic signed [SAMPLE_W-1:0] fs_r;
  logic signed [32:0]         fbp_r;
  logic signed [33:0]         dprod_r, mixp_r;
  logic [20:0]                u_r;
  logic [18:0]                fbt_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;

  logic signed [32:0]       fbp;
  logic [SAMPLE_W-1:0]      y0m, y1m;
  logic signed [16:0]       diff;
  logic signed [33:0]       dprod;
  logic signed [37:0]       fbx, fb19;
  logic [20:0]              u;
  logic signed [33:0]       dround;
  logic [17:0]              dfull;
  logic [42:0]              q5p;
  logic [18:0]              q5;
  logic [SUM_W-1:0]         ssum;
  logic [SAMPLE_W-1:0]      stored;
  logic signed [16:0]       mdiff;
  logic signed [33:0]       mixp;
  logic signed [33:0]       mround;
  logic [17:0]              mfull;

  assign {j_x, j_wp, j_i0, j_i1, j_f, j_w0, j_w1} = pop_data;

  assign pop_ready  = (state_r == S_READ);
  assign take       = pop_ready && pop_valid;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;

  assign fbp = fs_r * $signed({1'b0, cfg.feedback_amount});

  // Words never written since reset read as zero.
  assign y0m   = w0_r ? y0_r : '0;
  assign y1m   = w1_r ? y1_r : '0;
  assign diff  = $signed({y1m[SAMPLE_W-1], y1m}) - $signed({y0m[SAMPLE_W-1], y0m});
  assign dprod = diff * $signed({1'b0, f_r});

  // Feedback gain 0.95 with rounding: floor((p*19 + 655360) / (5 * 2**18)).
  assign fbx  = {{5{fbp_r[32]}}, fbp_r};
  assign fb19 = (fbx <<< 4) + (fbx <<< 1) + fbx + 38'sd655360;
  assign u    = {fb19[37], fb19[37:18]} + 21'd1310720;

  assign dround = dprod_r + 34'sd32768;
  assign dfull  = {{2{y0h_r[SAMPLE_W-1]}}, y0h_r} + dround[33:16];
  assign q5p    = 43'(u_r) * 43'(RECIP5);
  assign q5     = q5p[42:24];

  assign ssum   = {{4{x_r[SAMPLE_W-1]}}, x_r} + {fbt_r[18], fbt_r};
  assign stored = sat_sample(ssum);
  assign mdiff  = $signed({delayed_r[SAMPLE_W-1], delayed_r})
                - $signed({x_r[SAMPLE_W-1], x_r});
  assign mixp   = mdiff * $signed({1'b0, cfg.wet_mix});

  assign mround = mixp_r + 34'sd32768;
  assign mfull  = {{2{x_r[SAMPLE_W-1]}}, x_r} + mround[33:16];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_READ: begin
        if (pop_valid) state_nxt = S_INTERP;
      end
      S_INTERP: state_nxt = S_FB;
      S_FB:     state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_READ;
      end
      default: state_nxt = S_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_READ;
      fs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WRITE) begin
        fs_r <= $signed(delayed_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      y0_r <= mem[j_i0];
      y1_r <= mem[j_i1];
    end
    if (state_r == S_WRITE) begin
      mem[wp_r] <= stored;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= j_x;
      wp_r  <= j_wp;
      f_r   <= j_f;
      w0_r  <= j_w0;
      w1_r  <= j_w1;
      fbp_r <= fbp;
    end
    if (state_r == S_INTERP) begin
      dprod_r <= dprod;
      y0h_r   <= y0m;
      u_r     <= u;
    end
    if (state_r == S_FB) begin
      delayed_r <= dfull[SAMPLE_W-1:0];
      fbt_r     <= q5 - 19'd262144;
    end
    if (state_r == S_WRITE) begin
      mixp_r <= mixp;
    end
    if (out_load) begin
      out_data_r <= sat_sample({{2{mfull[17]}}, mfull});
    end
  end

endmodule

`default_nettype wire

[hw/rtl/modulated_delay_line_interp_core.sv]
// Modulated delay line core: a pipelined front end finds the delay and read
// addresses, and a queue decouples it from the delay memory back end.
// The back end takes a new item only after its read, interpolate, feedback,
// write and output steps for the last one are done. Synchronous reset (rst_n
// low) restores the control and configuration registers to their defaults;
// unwritten memory words read as zero.
`default_nettype none

module modulated_delay_line_interp_core #(
  parameter int DEPTH  = mdli_pkg::DEPTH_DEF,
  parameter int QDEPTH = mdli_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,  // audio_in, modulation
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [15:0]                        out_tdata, // audio_out
  input  wire logic                          cfg_wr_en,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [mdli_pkg::RATE_W-1:0]   cfg_wdata
);
  import mdli_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int ENTRY_W = SAMPLE_W + 3 * AW + FRAC_W + 2;

  mdli_cfg_t cfg_r;

  logic               q_push_valid, q_push_ready;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop_valid, q_pop_ready;
  logic [ENTRY_W-1:0] q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_knob       <= '0;
      cfg_r.feedback_amount <= '0;
      cfg_r.wet_mix         <= '0;
      cfg_r.sample_rate     <= RATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TIME_KNOB:   cfg_r.time_knob       <= cfg_wdata[KNOB_W-1:0];
        CFG_FEEDBACK:    cfg_r.feedback_amount <= cfg_wdata[KNOB_W-1:0];
        CFG_WET_MIX:     cfg_r.wet_mix         <= cfg_wdata[KNOB_W-1:0];
        CFG_SAMPLE_RATE: cfg_r.sample_rate     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mdli_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[15:0]),
    .in_mod    (in_tdata[31:16]),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data)
  );

  mdli_queue #(
    .WIDTH (ENTRY_W),
    .QDEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  mdli_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sample(out_tdata)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for modulated_delay_line_interp_core: random and directed samples
// are checked against a cycle-free model of the interpolating delay line with feedback.
// Depends only on mdli_pkg and the core itself.
`timescale 1ns / 100ps

module tb_top;
  import mdli_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 14;
  localparam int PHASE_ITEMS   = 100;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // audio_in, modulation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // audio_out
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_addr   = CFG_TIME_KNOB;
  logic [17:0] cfg_wdata  = '0;

  logic signed [15:0] line_mem [LINE_DEPTH];
  longint             wr_ptr_m;
  logic signed [15:0] fb_prev;
  logic [15:0]        knob_m;
  logic [15:0]        fb_amt_m;
  logic [15:0]        wet_m;
  logic [17:0]        rate_m;

  logic [15:0] pending_mix [$];
  logic [15:0] next_mix;
  int          errors      = 0;
  int          idle_pct    = 14;
  int          stall_cycles = 0;

  modulated_delay_line_interp_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) begin
      return 16'h7fff;
    end else if (v < -32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [15:0] delay_line_step(input logic signed [15:0] x,
                                                  input logic signed [15:0] m);
    longint dly, dint, dfrac, f, i0, i1, y0, y1, delayed, fb_term, mix;
    dly = longint'(knob_m) * longint'(rate_m) * longint'(49152 + int'(m)) / 16384000;
    dint = (dly >> 16) % LINE_DEPTH;
    dfrac = dly % 65536;
    if (dfrac != 0) begin
      dint = dint + 1;
      f = 65536 - dfrac;
    end else begin
      f = 0;
    end
    i0 = (wr_ptr_m + 2 * LINE_DEPTH - dint) % LINE_DEPTH;
    i1 = (i0 + 1) % LINE_DEPTH;
    y0 = longint'(line_mem[i0]);
    y1 = longint'(line_mem[i1]);
    delayed = (y0 * (65536 - f) + y1 * f + 32768) >>> 16;
    fb_term = floor_quot(longint'(fb_prev) * longint'(fb_amt_m) * 19 + 655360, 1310720);
    line_mem[wr_ptr_m] = clip16(longint'(x) + fb_term);
    fb_prev = delayed[15:0];
    mix = (longint'(x) * (65536 - longint'(wet_m)) + delayed * longint'(wet_m) + 32768) >>> 16;
    wr_ptr_m = (wr_ptr_m + 1) % LINE_DEPTH;
    return clip16(mix);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] m);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {m, x};
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_mix.push_back(delay_line_step(x, m));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_mix.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [17:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] tk, input logic [15:0] fb,
                               input logic [15:0] wet, input logic [17:0] rate);
    drain_results();
    write_reg(CFG_TIME_KNOB, 18'(tk));
    write_reg(CFG_FEEDBACK, 18'(fb));
    write_reg(CFG_WET_MIX, 18'(wet));
    write_reg(CFG_SAMPLE_RATE, rate);
    cfg_wr_en <= 1'b0;
    knob_m   = tk;
    fb_amt_m = fb;
    wet_m    = wet;
    rate_m   = rate;
  endtask

  task automatic load_random_settings();
    logic [15:0] tk;
    logic [17:0] rate;
    tk = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 3000));
    case ($urandom_range(0, 3))
      0: rate = 18'd8000;
      1: rate = RATE_RST;
      2: rate = 18'd192000;
      default: rate = 18'($urandom_range(0, 262143));
    endcase
    load_settings(tk, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), rate);
  endtask

  task automatic send_random_samples(input int count);
    logic signed [15:0] x;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: x = 16'sh7fff;
        1: x = 16'sh8000;
        default: x = 16'($urandom);
      endcase
      send_sample(x, 16'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0001, 16'shffff);
  endtask

  task automatic test_short_feedback();
    load_settings(16'd200, 16'hffff, 16'hffff, 18'd192000);
    for (int n = 0; n < 10; n++) begin
      send_sample((n % 4 < 2) ? 16'sh7fff : 16'sh8000, n[0] ? 16'sh7fff : 16'sh8000);
    end
  endtask

  task automatic test_extreme_settings();
    load_settings(16'hffff, 16'hffff, 16'h8000, 18'h3ffff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh1234, 16'sh0000);
    send_sample(16'shedcb, 16'sh4000);
    load_settings(16'hffff, 16'h0000, 16'hffff, 18'd0);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 11; p++) begin
      load_random_settings();
      send_random_samples(PHASE_ITEMS);
    end
    load_settings(16'h0000, 16'hffff, 16'hffff, 18'd8000);
    send_random_samples(PHASE_ITEMS);
  endtask

  task automatic test_no_idle_stretch();
    idle_pct = 0;
    load_random_settings();
    send_random_samples(PHASE_ITEMS);
    drain_results();
    idle_pct = 14;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mix.size() == 0) begin
        note_error($sformatf("audio_out %h arrived with no item outstanding", out_tdata));
      end else begin
        next_mix = pending_mix.pop_front();
        if (out_tdata !== next_mix) begin
          note_error($sformatf("audio_out expected %h got %h", next_mix, out_tdata));
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < LINE_DEPTH; a++) begin
      line_mem[a] = '0;
    end
    wr_ptr_m = 0;
    fb_prev  = '0;
    knob_m   = '0;
    fb_amt_m = '0;
    wet_m    = '0;
    rate_m   = RATE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_short_feedback();
    test_extreme_settings();
    test_random_phases();
    test_no_idle_stretch();
    if (pending_mix.size() > 0) begin
      note_error($sformatf("%0d results never arrived", pending_mix.size()));
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
